FILE: rtl/core/lottery_bid_process_scheduler_unit_assert.svh
// Assertion helpers for the scheduler RTL.
// Both expect a signal named clk in the enclosing module; LBPS_ASSERT also uses rst.
`ifndef LOTTERY_BID_PROCESS_SCHEDULER_UNIT_ASSERT_SVH
`define LOTTERY_BID_PROCESS_SCHEDULER_UNIT_ASSERT_SVH

// Checked outside of reset.
`define LBPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define LBPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/lbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lbps_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int SLOT_W    = 6;
  localparam int SUB_W     = 10;
  localparam int SUM_W     = 20;
  localparam int TOTAL_W   = 13;
  localparam int DRAW_W    = 7;

  // Random generator and draw reduction
  localparam logic [31:0] LCG_MUL  = 32'd1103515245;
  localparam logic [31:0] LCG_ADD  = 32'd12345;
  localparam logic [15:0] DRAW_MAG = 16'd41944;   // ceil(2^22 / 100)
  localparam int          DRAW_SH  = 22;
  localparam logic [14:0] DRAW_MOD = 15'd100;

  // Charging
  localparam logic [31:0]      TIME_STEP = 32'd10;
  localparam logic [SUM_W-1:0] BID_SCALE = 20'd10;
  localparam logic [SUM_W-1:0] SUB_UNIT  = 20'd1000;
  localparam logic [20:0]      K_MAG     = 21'd1073742; // ceil(2^30 / 1000)
  localparam int               K_SH      = 30;

  typedef enum logic [1:0] {
    CMD_SKIP  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SCHED = 2'd2
  } cmd_op_t;

  typedef struct packed {
    logic        func;
    logic [5:0]  slot;
    logic        runnable;
    logic        kind;
    logic [7:0]  share;
    logic [15:0] bid;
    logic        clear_counts;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  grant_slot;
    logic        grant_kind;
    logic [31:0] chosen_count;
    logic [31:0] run_time_ms;
    logic [31:0] whole_charge;
    logic [9:0]  sub_charge;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        runnable;
    logic        kind;
    logic [7:0]  share;
    logic [15:0] bid;
  } param_t;

  typedef struct packed {
    logic [31:0]      chosen;
    logic [31:0]      rtime;
    logic [31:0]      whole;
    logic [SUB_W-1:0] sub;
  } cnt_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [SLOT_W-1:0] slot;
    param_t            prm;
    logic              clear;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/lbps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module lbps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/lbps_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module lbps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = buf_q[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_q[wptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : AW'(wptr + 1'b1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : AW'(rptr + 1'b1);
      end
      count <= AW'(0) + count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/lbps_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lbps_front #(
  parameter int SLOTS = lbps_pkg::SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire lbps_pkg::in_item_t  item,
  input  wire logic                cmd_pop,
  output logic                     cmd_empty,
  output lbps_pkg::cmd_t           cmd
);

  lbps_pkg::cmd_t cmd_in;
  logic           slot_ok;

  // Classify the request: schedule, slot write, or write beyond the table
  assign slot_ok = ({1'b0, item.slot} < 7'(SLOTS));

  always_comb begin
    cmd_in.slot         = item.slot;
    cmd_in.prm.runnable = item.runnable;
    cmd_in.prm.kind     = item.kind;
    cmd_in.prm.share    = item.share;
    cmd_in.prm.bid      = item.bid;
    cmd_in.clear        = item.clear_counts;
    if (item.func) begin
      cmd_in.op = lbps_pkg::CMD_SCHED;
    end else if (slot_ok) begin
      cmd_in.op = lbps_pkg::CMD_WRITE;
    end else begin
      cmd_in.op = lbps_pkg::CMD_SKIP;
    end
  end

  // Command queue toward the back end
  lbps_fifo #(
    .WIDTH ($bits(lbps_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule
`default_nettype wire

FILE: rtl/core/lbps_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lottery_bid_process_scheduler_unit_assert.svh"
module lbps_back #(
  parameter int SLOTS = lbps_pkg::SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_empty,
  output logic                    cmd_pop,
  input  wire lbps_pkg::cmd_t     cmd,
  output logic                    empty,
  input  wire logic               pop,
  output lbps_pkg::out_item_t     result
);

  localparam int IW = $clog2(SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_LCG, S_DRAW_Q, S_DRAW_R, S_P1_ADDR, S_P1_DATA, S_DECIDE,
    S_P2_ADDR, S_P2_DATA, S_DIV, S_WB
  } state_t;

  typedef enum logic [1:0] {
    M_SINGLE, M_ALL_RUN, M_ALL_SPOT
  } mode_t;

  state_t state;
  mode_t  mode;
  logic [IW-1:0] idx;
  logic [IW-1:0] end_idx;

  // Slot table storage
  logic [SLOTS-1:0] pvalid;
  logic [SLOTS-1:0] cvalid;
  logic             rd_pv;
  logic             rd_cv;
  logic             p_we;
  logic             c_we;
  lbps_pkg::param_t p_rdata;
  lbps_pkg::cnt_t   c_rdata;
  lbps_pkg::cnt_t   c_wdata;
  lbps_pkg::param_t p;
  lbps_pkg::cnt_t   c;

  // Draw
  logic [31:0] rv;
  logic [8:0]  dq;
  logic [lbps_pkg::DRAW_W-1:0] draw;
  logic [14:0] draw_x;
  logic [30:0] draw_prod;

  // Scan summary
  logic        have_spot;
  logic        same_bid;
  logic [15:0] ref_bid;
  logic [15:0] best_bid;
  logic [IW-1:0] best;
  logic [IW-1:0] last_spot;
  logic [IW-1:0] last_run;
  logic        any_run;
  logic        won;
  logic [IW-1:0] winner;
  logic [lbps_pkg::TOTAL_W-1:0] total;
  logic [lbps_pkg::TOTAL_W-1:0] total_n;

  // Grant in flight
  logic        spot_chg;
  logic        e_kind;
  logic        e_last;
  lbps_pkg::cnt_t e_cnt;
  logic [lbps_pkg::SUM_W-1:0] e_sum;
  logic [lbps_pkg::SUB_W-1:0] e_q;
  logic [40:0] k_prod;
  logic [lbps_pkg::SUM_W-1:0] sub_rem;
  logic        qual;

  // Result queue
  logic                out_full;
  logic                out_push;
  lbps_pkg::out_item_t res;

  assign p = rd_pv ? p_rdata : '0;
  assign c = rd_cv ? c_rdata : '0;

  assign cmd_pop = (state == S_IDLE) && !cmd_empty;
  assign p_we    = cmd_pop && (cmd.op == lbps_pkg::CMD_WRITE);
  assign out_push = (state == S_WB) && !out_full;
  assign c_we     = out_push;

  assign draw_x    = rv[30:16];
  assign draw_prod = 31'(draw_x) * 31'(lbps_pkg::DRAW_MAG);
  assign total_n   = total + lbps_pkg::TOTAL_W'(p.share[7:1]);
  assign k_prod    = 41'(e_sum - 20'd1) * 41'(lbps_pkg::K_MAG);
  assign sub_rem   = e_sum - 20'(e_q) * lbps_pkg::SUB_UNIT;

  assign qual = (mode == M_SINGLE) ||
                (p.runnable && ((mode == M_ALL_RUN) || !p.kind));

  // Counter update for the grant
  always_comb begin
    c_wdata        = e_cnt;
    c_wdata.chosen = e_cnt.chosen + 32'd1;
    c_wdata.rtime  = e_cnt.rtime + lbps_pkg::TIME_STEP;
    if (!spot_chg) begin
      c_wdata.whole = e_cnt.whole + 32'd1;
    end else if (e_sum > lbps_pkg::SUB_UNIT) begin
      c_wdata.whole = e_cnt.whole + 32'(e_q);
      c_wdata.sub   = sub_rem[lbps_pkg::SUB_W-1:0];
    end else begin
      c_wdata.sub   = e_sum[lbps_pkg::SUB_W-1:0];
    end
  end

  always_comb begin
    res.grant_slot   = lbps_pkg::SLOT_W'(idx);
    res.grant_kind   = e_kind;
    res.chosen_count = c_wdata.chosen;
    res.run_time_ms  = c_wdata.rtime;
    res.whole_charge = c_wdata.whole;
    res.sub_charge   = c_wdata.sub;
    res.last         = e_last;
  end

  lbps_ram #(
    .WIDTH ($bits(lbps_pkg::param_t)),
    .DEPTH (SLOTS)
  ) u_param_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (cmd.slot[IW-1:0]),
    .wdata (cmd.prm),
    .raddr (idx),
    .rdata (p_rdata)
  );

  lbps_ram #(
    .WIDTH ($bits(lbps_pkg::cnt_t)),
    .DEPTH (SLOTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (idx),
    .wdata (c_wdata),
    .raddr (idx),
    .rdata (c_rdata)
  );

  lbps_fifo #(
    .WIDTH ($bits(lbps_pkg::out_item_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (res),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

  // Valid bits stand in for the zeroed table; they follow the read address
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= '0;
      cvalid <= '0;
      rd_pv  <= 1'b0;
      rd_cv  <= 1'b0;
    end else begin
      rd_pv <= pvalid[idx];
      rd_cv <= cvalid[idx];
      if (p_we) begin
        pvalid[cmd.slot[IW-1:0]] <= 1'b1;
        if (cmd.clear) begin
          cvalid[cmd.slot[IW-1:0]] <= 1'b0;
        end
      end
      if (c_we) begin
        cvalid[idx] <= 1'b1;
      end
    end
  end

  // Round sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rv    <= 32'd1;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_pop && (cmd.op == lbps_pkg::CMD_SCHED)) begin
            state <= S_LCG;
          end
        end
        S_LCG: begin
          rv        <= rv * lbps_pkg::LCG_MUL + lbps_pkg::LCG_ADD;
          have_spot <= 1'b0;
          same_bid  <= 1'b1;
          any_run   <= 1'b0;
          won       <= 1'b0;
          total     <= '0;
          state     <= S_DRAW_Q;
        end
        S_DRAW_Q: begin
          dq    <= draw_prod[lbps_pkg::DRAW_SH+8:lbps_pkg::DRAW_SH];
          state <= S_DRAW_R;
        end
        S_DRAW_R: begin
          draw  <= lbps_pkg::DRAW_W'(draw_x - 15'(dq) * lbps_pkg::DRAW_MOD);
          idx   <= '0;
          state <= S_P1_ADDR;
        end
        S_P1_ADDR: begin
          state <= S_P1_DATA;
        end
        S_P1_DATA: begin
          // spot bids and first highest bid
          if (p.runnable && !p.kind) begin
            last_spot <= idx;
            if (!have_spot) begin
              have_spot <= 1'b1;
              ref_bid   <= p.bid;
              best_bid  <= p.bid;
              best      <= idx;
            end else begin
              if (p.bid != ref_bid) begin
                same_bid <= 1'b0;
              end
              if (p.bid > best_bid) begin
                best_bid <= p.bid;
                best     <= idx;
              end
            end
          end
          if (p.runnable) begin
            any_run  <= 1'b1;
            last_run <= idx;
          end
          // lottery: first reserved slot whose running total reaches the draw
          if (p.runnable && p.kind && !won) begin
            total <= total_n;
            if (total_n >= lbps_pkg::TOTAL_W'(draw)) begin
              won    <= 1'b1;
              winner <= idx;
            end
          end
          if (idx == IW'(SLOTS-1)) begin
            state <= S_DECIDE;
          end else begin
            idx   <= IW'(idx + 1'b1);
            state <= S_P1_ADDR;
          end
        end
        S_DECIDE: begin
          if (won) begin
            mode     <= M_SINGLE;
            idx      <= winner;
            spot_chg <= 1'b0;
            state    <= S_P2_ADDR;
          end else if (!have_spot) begin
            mode     <= M_ALL_RUN;
            end_idx  <= last_run;
            idx      <= '0;
            spot_chg <= 1'b0;
            state    <= any_run ? S_P2_ADDR : S_IDLE;
          end else if (!same_bid) begin
            mode     <= M_SINGLE;
            idx      <= best;
            spot_chg <= 1'b1;
            state    <= S_P2_ADDR;
          end else begin
            mode     <= M_ALL_SPOT;
            end_idx  <= last_spot;
            idx      <= '0;
            spot_chg <= 1'b1;
            state    <= S_P2_ADDR;
          end
        end
        S_P2_ADDR: begin
          state <= S_P2_DATA;
        end
        S_P2_DATA: begin
          if (qual) begin
            e_cnt  <= c;
            e_kind <= p.kind;
            e_sum  <= lbps_pkg::SUM_W'(c.sub) +
                      lbps_pkg::SUM_W'(p.bid) * lbps_pkg::BID_SCALE;
            e_last <= (mode == M_SINGLE) || (idx == end_idx);
            state  <= S_DIV;
          end else if (idx == IW'(SLOTS-1)) begin
            state <= S_IDLE;
          end else begin
            idx   <= IW'(idx + 1'b1);
            state <= S_P2_ADDR;
          end
        end
        S_DIV: begin
          e_q   <= k_prod[lbps_pkg::K_SH+9:lbps_pkg::K_SH];
          state <= S_WB;
        end
        S_WB: begin
          if (!out_full) begin
            if (e_last || (idx == IW'(SLOTS-1))) begin
              state <= S_IDLE;
            end else begin
              idx   <= IW'(idx + 1'b1);
              state <= S_P2_ADDR;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LBPS_ASSERT(a_last_ends_round, out_push && res.last |=> state == S_IDLE, "round ran past last")
  `LBPS_ASSERT(a_pop_only_idle, cmd_pop |-> state == S_IDLE && !cmd_empty, "command taken mid round")
  `LBPS_ASSERT(a_single_is_last, state == S_WB && mode == M_SINGLE |-> e_last, "single grant not last")
  `LBPS_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> state == S_IDLE, "sequencer not idle after reset")

endmodule
`default_nettype wire

FILE: rtl/core/lottery_bid_process_scheduler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Lottery scheduler with bid-priority fallback over a table of SLOTS process slots.
// Request channel: queue-style, push/full. A request is taken when push is high
// and full is low. func = 0 writes one slot (no result); func = 1 runs a round.
// Result channel: queue-style, empty/pop. The oldest grant sits on result while
// empty is low and leaves when pop is high. Each grant of a round is one result;
// the final one carries last. A round with no runnable slot gives no result.
// A two-entry command queue sits in front; a two-entry result queue sits behind.
// A slot write is taken in the idle state and leaves the back end idle. A round
// steps the generator, forms the draw quotient then remainder, scans every slot
// (address, then data) and decides; each grant then reads its slot, divides and
// writes back. When every runnable slot is granted, the pass ends at the last one.
// A full result queue stalls the round at its next grant; requests keep queueing
// until the command queue fills.
// Reset (synchronous, rst high): every slot reads as zero, the generator holds 1,
// both queues empty.
module lottery_bid_process_scheduler_unit #(
  parameter int SLOTS = lbps_pkg::SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire lbps_pkg::in_item_t  item,
  output logic                     empty,
  input  wire logic                pop,
  output lbps_pkg::out_item_t      result
);

  logic           cmd_pop;
  logic           cmd_empty;
  lbps_pkg::cmd_t cmd;

  lbps_front #(.SLOTS(SLOTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  lbps_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int NSLOT = 64;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                pop = 1'b0;
  logic                full;
  logic                empty;
  lbps_pkg::in_item_t  item = '0;
  lbps_pkg::out_item_t result;

  lottery_bid_process_scheduler_unit u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scheduler state mirror
  logic        m_run [NSLOT];
  logic        m_kind [NSLOT];
  logic [7:0]  m_share [NSLOT];
  logic [15:0] m_bid [NSLOT];
  logic [31:0] m_chosen [NSLOT];
  logic [31:0] m_time [NSLOT];
  logic [31:0] m_whole [NSLOT];
  logic [9:0]  m_sub [NSLOT];
  logic [31:0] lcg;

  lbps_pkg::out_item_t grant_q[$];
  int errors = 0;
  int rounds = 0;
  int grants_seen = 0;
  bit burst_on = 1'b0;
  int burst_left = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // charge one grant and queue the expected result
  function automatic void grant(input int s, input bit spot);
    lbps_pkg::out_item_t g;
    logic [31:0] sub;
    m_chosen[s] += 1;
    m_time[s] += 10;
    if (spot) begin
      sub = 32'(m_sub[s]) + 32'd10 * 32'(m_bid[s]);
      if (sub > 1000) begin
        m_whole[s] += (sub - 1) / 1000;
        sub -= 1000 * ((sub - 1) / 1000);
      end
      m_sub[s] = sub[9:0];
    end else begin
      m_whole[s] += 1;
    end
    g.grant_slot = 6'(s);
    g.grant_kind = m_kind[s];
    g.chosen_count = m_chosen[s];
    g.run_time_ms = m_time[s];
    g.whole_charge = m_whole[s];
    g.sub_charge = m_sub[s];
    g.last = 1'b0;
    grant_q.push_back(g);
  endfunction

  function automatic void predict_request(input lbps_pkg::in_item_t it);
    logic [31:0] draw, total;
    bit have_spot, same, first;
    logic [15:0] rbid;
    int q_start, best;
    if (!it.func) begin
      m_run[it.slot] = it.runnable;
      m_kind[it.slot] = it.kind;
      m_share[it.slot] = it.share;
      m_bid[it.slot] = it.bid;
      if (it.clear_counts) begin
        m_chosen[it.slot] = 0;
        m_time[it.slot] = 0;
        m_whole[it.slot] = 0;
        m_sub[it.slot] = 0;
      end
      return;
    end
    rounds++;
    lcg = lcg * 32'd1103515245 + 32'd12345;
    draw = ((lcg >> 16) % 32768) % 100;
    have_spot = 0; same = 1; first = 1; rbid = 0; total = 0;
    q_start = grant_q.size();
    for (int s = 0; s < NSLOT; s++)
      if (m_run[s] && !m_kind[s]) begin
        have_spot = 1;
        if (first) begin
          rbid = m_bid[s];
          first = 0;
        end else if (m_bid[s] != rbid) same = 0;
      end
    // reserved lottery: first slot reaching the draw wins alone
    for (int s = 0; s < NSLOT; s++) begin
      if (!m_run[s] || !m_kind[s]) continue;
      total += m_share[s] / 2;
      if (total >= draw) begin
        grant(s, 0);
        grant_q[$].last = 1'b1;
        return;
      end
    end
    if (!have_spot) begin
      for (int s = 0; s < NSLOT; s++)
        if (m_run[s]) grant(s, 0);
    end else if (!same) begin
      best = -1;
      for (int s = 0; s < NSLOT; s++)
        if (m_run[s] && !m_kind[s] && (best < 0 || m_bid[s] > m_bid[best])) best = s;
      grant(best, 1);
    end else begin
      for (int s = 0; s < NSLOT; s++)
        if (m_run[s] && !m_kind[s]) grant(s, 1);
    end
    if (grant_q.size() > q_start) grant_q[$].last = 1'b1;
  endfunction

  // send one request, with bursty random gaps; push stays high within a burst
  task automatic send_request(input lbps_pkg::in_item_t it);
    if (burst_left == 0) begin
      burst_on = $urandom_range(0, 3) != 0;
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    if (!burst_on) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_request(it);
  endtask

  // receiver stall pattern plus result checking
  int stall_phase = 0;
  always @(posedge clk) begin
    lbps_pkg::out_item_t w;
    if (!rst && pop && !empty) begin
      grants_seen++;
      if (grant_q.size() == 0) begin
        $display("unexpected grant slot %0d at %0t", result.grant_slot, $realtime);
        errors++;
      end else begin
        w = grant_q.pop_front();
        if (result.grant_slot !== w.grant_slot) report("grant_slot", result.grant_slot, w.grant_slot);
        if (result.grant_kind !== w.grant_kind) report("grant_kind", result.grant_kind, w.grant_kind);
        if (result.chosen_count !== w.chosen_count)
          report("chosen_count", result.chosen_count, w.chosen_count);
        if (result.run_time_ms !== w.run_time_ms)
          report("run_time_ms", result.run_time_ms, w.run_time_ms);
        if (result.whole_charge !== w.whole_charge)
          report("whole_charge", result.whole_charge, w.whole_charge);
        if (result.sub_charge !== w.sub_charge) report("sub_charge", result.sub_charge, w.sub_charge);
        if (result.last !== w.last) report("last", result.last, w.last);
      end
    end
    stall_phase = (stall_phase + 1) % 400;
    if (stall_phase < 100) pop <= 1'b1;
    else if (stall_phase < 140) pop <= 1'b0;
    else pop <= $urandom_range(0, 2) != 0;
  end

  function automatic lbps_pkg::in_item_t wr(input int s, input bit r, input bit k, input int sh,
                                            input int b, input bit clr);
    lbps_pkg::in_item_t it;
    it = '0;
    it.func = 1'b0; it.slot = 6'(s); it.runnable = r; it.kind = k;
    it.share = 8'(sh); it.bid = 16'(b); it.clear_counts = clr;
    return it;
  endfunction

  function automatic lbps_pkg::in_item_t sched();
    lbps_pkg::in_item_t it;
    it = lbps_pkg::in_item_t'($bits(lbps_pkg::in_item_t)'({$urandom, $urandom}));
    it.func = 1'b1;
    return it;
  endfunction

  task automatic drain();
    push <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // empty table, all-reserved, spot priority, equal bids, extremes
  task automatic test_directed();
    send_request(sched());
    send_request(wr(0, 1, 1, 0, 65535, 1));
    send_request(wr(63, 1, 1, 255, 0, 0));
    send_request(sched());
    send_request(sched());
    send_request(wr(5, 1, 0, 200, 65535, 1));
    send_request(wr(9, 1, 0, 0, 100, 1));
    send_request(wr(0, 0, 1, 0, 0, 0));
    send_request(wr(63, 0, 1, 0, 0, 0));
    send_request(sched());
    send_request(sched());
    send_request(wr(9, 1, 0, 7, 65535, 0));
    send_request(sched());
    send_request(wr(33, 1, 0, 1, 65535, 1));
    send_request(sched());
    send_request(wr(20, 1, 1, 2, 1, 0));
    send_request(sched());
    send_request(sched());
    send_request(wr(20, 0, 0, 0, 0, 1));
    drain();
  endtask

  // random tables built of a few live slots, then rounds
  task automatic test_random(input int n);
    lbps_pkg::in_item_t it;
    int b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        send_request(sched());
      end else begin
        b = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 3) * 40;
        it = wr($urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 7),
                $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 4) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 60),
                b, $urandom_range(0, 5) == 0);
        send_request(it);
      end
      if (i == n / 2) begin
        push <= 1'b0;
        while (grant_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
    end
  endtask

  initial begin
    for (int s = 0; s < NSLOT; s++) begin
      m_run[s] = 0; m_kind[s] = 0; m_share[s] = 0; m_bid[s] = 0;
      m_chosen[s] = 0; m_time[s] = 0; m_whole[s] = 0; m_sub[s] = 0;
    end
    lcg = 32'd1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    drain();
    $display("covered %0d scheduling rounds and %0d grants", rounds, grants_seen);
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("testbench: done, errors");
    $finish;
  end
endmodule
